@@ design/sejs_pkg.sv @@
package sejs_pkg;

    localparam int unsigned PAGE_BYTES_DEF   = 64;
    localparam int unsigned EEPROM_BYTES_DEF = 32768;

    localparam logic [31:0] WIN_LOW_RST = 32'h4000_0000;
    localparam logic [31:0] WIN_END_RST = 32'h4006_0000;

    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_WRITE = 8'h02;
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam int unsigned WEL_BIT  = 1;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_LOW = 1'b0,
        CFG_WIN_END = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_FRAME = 2'd2,
        REQ_RAM   = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        KIND_FRAME = 2'd0,
        KIND_STORE = 2'd1,
        KIND_FETCH = 2'd2,
        KIND_DONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        JC_OK         = 3'd0,
        JC_BUSY_SAME  = 3'd1,
        JC_BUSY_OTHER = 3'd2,
        JC_LEN_ERR    = 3'd3,
        JC_EE_ERR     = 3'd4,
        JC_RAM_ERR    = 3'd5,
        JC_FAIL       = 3'd6
    } t_job_code;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RD_CMD   = 4'd1,
        PH_RD_AH    = 4'd2,
        PH_RD_AL    = 4'd3,
        PH_RD_DATA  = 4'd4,
        PH_WR_WREN  = 4'd5,
        PH_WR_RDSR  = 4'd6,
        PH_WR_STAT  = 4'd7,
        PH_WR_CMD   = 4'd8,
        PH_WR_AH    = 4'd9,
        PH_WR_AL    = 4'd10,
        PH_WR_FETCH = 4'd11,
        PH_WR_DATA  = 4'd12
    } t_phase;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] ee_addr;
        logic [31:0] ram_addr;
        logic [15:0] length;
        logic [7:0]  rx_byte;
        logic        spi_error;
        logic [7:0]  ram_data;
    } t_req;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  tx_byte;
        logic        hold_select;
        logic [31:0] mem_addr;
        logic [7:0]  mem_byte;
        logic [2:0]  job_code;
        logic        busy_res;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_emit;

    function automatic t_res res_frame(logic [7:0] tx, logic hold);
        t_res r;
        r = '0;
        r.out_kind    = KIND_FRAME;
        r.tx_byte     = tx;
        r.hold_select = hold;
        r.last        = 1'b1;
        return r;
    endfunction

    function automatic t_res res_mem(t_kind kind, logic [31:0] addr, logic [7:0] data,
                                     logic lst);
        t_res r;
        r = '0;
        r.out_kind = kind;
        r.mem_addr = addr;
        r.mem_byte = data;
        r.last     = lst;
        return r;
    endfunction

    function automatic t_res res_done(t_job_code code);
        t_res r;
        r = '0;
        r.out_kind = KIND_DONE;
        r.job_code = code;
        r.last     = 1'b1;
        return r;
    endfunction

endpackage

@@ design/spi_eeprom_job_sequencer.sv @@
// Results of an accepted item are written into the result queue at the accepting edge.
// Throughput: one item per cycle; an item yields zero, one or two results through a
// four-entry result queue, and the input is ready while two entries are free.
// Page remainder for a write job is computed in a pipelined multiply unit behind the start.
// Reset (synchronous, active low): no job, idle phase, empty queue, RAM window at defaults.
module spi_eeprom_job_sequencer #(
    parameter int unsigned PAGE_BYTES   = sejs_pkg::PAGE_BYTES_DEF,
    parameter int unsigned EEPROM_BYTES = sejs_pkg::EEPROM_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  sejs_pkg::t_req                    i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output sejs_pkg::t_res                    o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sejs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    logic [31:0]      r_win_low;
    logic [31:0]      r_win_end;
    logic             acc;
    sejs_pkg::t_emit  emit;

    assign o_cfg_ready = 1'b1;
    assign acc = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_low <= sejs_pkg::WIN_LOW_RST;
            r_win_end <= sejs_pkg::WIN_END_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sejs_pkg::CFG_WIN_LOW: r_win_low <= i_cfg_data;
                sejs_pkg::CFG_WIN_END: r_win_end <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sejs_core #(
        .PAGE_BYTES   (PAGE_BYTES),
        .EEPROM_BYTES (EEPROM_BYTES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_item    (i_in_data),
        .i_win_low (r_win_low),
        .i_win_end (r_win_end),
        .o_emit    (emit)
    );

    sejs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

@@ design/sejs_pgrem.sv @@
module sejs_pgrem #(
    parameter int unsigned PAGE_BYTES = sejs_pkg::PAGE_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic [15:0]                         i_x,
    output logic [$clog2(PAGE_BYTES + 1)-1:0]   o_room
);

    localparam int PW = $clog2(PAGE_BYTES + 1);
    localparam int SH = 24;
    localparam longint unsigned RECIP = (64'd1 << SH) / PAGE_BYTES;
    localparam int MW = $clog2(RECIP + 1);
    localparam int PRW = 16 + MW;
    localparam logic [MW-1:0] RECIP_C = MW'(RECIP);
    localparam logic [PW:0] PAGE_W = (PW + 1)'(PAGE_BYTES);

    logic [15:0]    r_x;
    logic [15:0]    r_x_d;
    logic [PRW-1:0] r_prod;
    logic [PW:0]    r_raw;
    logic [15:0]    quot;
    logic [15:0]    qp;
    logic [PW:0]    rem;

    // quotient estimate is exact or one low
    assign quot = 16'(r_prod >> SH);
    assign qp   = quot * 16'(PAGE_BYTES);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_x;
        end
        r_x_d  <= r_x;
        r_prod <= PRW'(r_x) * PRW'(RECIP_C);
        r_raw  <= (PW + 1)'(r_x_d - qp);
    end

    assign rem    = (r_raw >= PAGE_W) ? (r_raw - PAGE_W) : r_raw;
    assign o_room = PW'(PAGE_W - rem);

endmodule

@@ design/sejs_core.sv @@
module sejs_core #(
    parameter int unsigned PAGE_BYTES   = sejs_pkg::PAGE_BYTES_DEF,
    parameter int unsigned EEPROM_BYTES = sejs_pkg::EEPROM_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_acc,
    input  sejs_pkg::t_req        i_item,
    input  logic [31:0]           i_win_low,
    input  logic [31:0]           i_win_end,
    output sejs_pkg::t_emit       o_emit
);

    localparam int PW = $clog2(PAGE_BYTES + 1);
    localparam logic [16:0]   EE_LIM    = 17'(EEPROM_BYTES);
    localparam logic [PW-1:0] CHUNK_ONE = PW'(1);

    logic                r_active;
    sejs_pkg::t_phase    r_phase;
    logic [15:0]         r_ee_start;
    logic [31:0]         r_ram_start;
    logic [15:0]         r_len;
    logic [15:0]         r_bytes_left;
    logic [PW-1:0]       r_chunk_left;
    logic [15:0]         r_ee_cur;
    logic [31:0]         r_ram_cur;

    logic                n_active;
    sejs_pkg::t_phase    n_phase;
    logic [15:0]         n_ee_start;
    logic [31:0]         n_ram_start;
    logic [15:0]         n_len;
    logic [15:0]         n_bytes_left;
    logic [PW-1:0]       n_chunk_left;
    logic [15:0]         n_ee_cur;
    logic [31:0]         n_ram_cur;

    sejs_pkg::t_emit     em;
    logic                div_load;
    logic [15:0]         div_x;
    logic [PW-1:0]       room;
    logic [PW-1:0]       chunk_first;
    logic [16:0]         ee_end;
    logic [32:0]         ram_end;
    logic                same_job;
    logic [15:0]         ee_nx;
    logic [31:0]         ram_nx;
    logic [15:0]         bl_dec;
    logic [PW-1:0]       ck_dec;

    sejs_pgrem #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_pgrem (
        .i_clk  (i_clk),
        .i_load (div_load),
        .i_x    (div_x),
        .o_room (room)
    );

    assign ee_end   = {1'b0, i_item.ee_addr} + {1'b0, i_item.length};
    assign ram_end  = {1'b0, i_item.ram_addr} + 33'(i_item.length);
    assign same_job = (i_item.ee_addr == r_ee_start) && (i_item.ram_addr == r_ram_start)
                      && (i_item.length == r_len);
    assign ee_nx    = r_ee_cur + 16'd1;
    assign ram_nx   = r_ram_cur + 32'd1;
    assign bl_dec   = r_bytes_left - 16'd1;
    assign ck_dec   = r_chunk_left - CHUNK_ONE;
    assign chunk_first = (16'(room) > r_bytes_left) ? PW'(r_bytes_left) : room;

    always_comb begin
        n_active     = r_active;
        n_phase      = r_phase;
        n_ee_start   = r_ee_start;
        n_ram_start  = r_ram_start;
        n_len        = r_len;
        n_bytes_left = r_bytes_left;
        n_chunk_left = r_chunk_left;
        n_ee_cur     = r_ee_cur;
        n_ram_cur    = r_ram_cur;
        em           = '0;
        div_load     = 1'b0;
        div_x        = i_item.ee_addr;

        if (i_acc) begin
            unique case (i_item.req_type)
                sejs_pkg::REQ_READ, sejs_pkg::REQ_WRITE: begin
                    em.cnt = 2'd1;
                    priority if (r_active) begin
                        em.r0 = sejs_pkg::res_done(same_job ? sejs_pkg::JC_BUSY_SAME
                                                            : sejs_pkg::JC_BUSY_OTHER);
                    end else if (i_item.length == 16'd0
                                 || {1'b0, i_item.length} >= EE_LIM) begin
                        em.r0 = sejs_pkg::res_done(sejs_pkg::JC_LEN_ERR);
                    end else if (ee_end > EE_LIM) begin
                        em.r0 = sejs_pkg::res_done(sejs_pkg::JC_EE_ERR);
                    end else if (i_item.ram_addr < i_win_low || ram_end > {1'b0, i_win_end}) begin
                        em.r0 = sejs_pkg::res_done(sejs_pkg::JC_RAM_ERR);
                    end else begin
                        n_active     = 1'b1;
                        n_ee_start   = i_item.ee_addr;
                        n_ram_start  = i_item.ram_addr;
                        n_len        = i_item.length;
                        n_bytes_left = i_item.length;
                        n_ee_cur     = i_item.ee_addr;
                        n_ram_cur    = i_item.ram_addr;
                        if (i_item.req_type == sejs_pkg::REQ_WRITE) begin
                            div_load = 1'b1;
                            n_phase  = sejs_pkg::PH_WR_WREN;
                            em.r0    = sejs_pkg::res_frame(sejs_pkg::CMD_WREN, 1'b0);
                        end else begin
                            n_phase = sejs_pkg::PH_RD_CMD;
                            em.r0   = sejs_pkg::res_frame(sejs_pkg::CMD_READ, 1'b1);
                        end
                    end
                end
                sejs_pkg::REQ_RAM: begin
                    if (r_phase == sejs_pkg::PH_WR_FETCH) begin
                        em.cnt  = 2'd1;
                        n_phase = sejs_pkg::PH_WR_DATA;
                        em.r0   = sejs_pkg::res_frame(i_item.ram_data,
                                                      r_chunk_left != CHUNK_ONE);
                    end
                end
                sejs_pkg::REQ_FRAME: begin
                    if (r_phase != sejs_pkg::PH_IDLE && r_phase != sejs_pkg::PH_WR_FETCH
                        && i_item.spi_error) begin
                        em.cnt   = 2'd1;
                        n_active = 1'b0;
                        n_phase  = sejs_pkg::PH_IDLE;
                        em.r0    = sejs_pkg::res_done(sejs_pkg::JC_FAIL);
                    end else begin
                        unique case (r_phase)
                            sejs_pkg::PH_RD_CMD, sejs_pkg::PH_WR_CMD: begin
                                em.cnt  = 2'd1;
                                n_phase = (r_phase == sejs_pkg::PH_RD_CMD)
                                          ? sejs_pkg::PH_RD_AH : sejs_pkg::PH_WR_AH;
                                em.r0   = sejs_pkg::res_frame(r_ee_cur[15:8], 1'b1);
                            end
                            sejs_pkg::PH_RD_AH, sejs_pkg::PH_WR_AH: begin
                                em.cnt  = 2'd1;
                                n_phase = (r_phase == sejs_pkg::PH_RD_AH)
                                          ? sejs_pkg::PH_RD_AL : sejs_pkg::PH_WR_AL;
                                em.r0   = sejs_pkg::res_frame(r_ee_cur[7:0], 1'b1);
                            end
                            sejs_pkg::PH_RD_AL: begin
                                em.cnt  = 2'd1;
                                n_phase = sejs_pkg::PH_RD_DATA;
                                em.r0   = sejs_pkg::res_frame(8'h00, r_bytes_left != 16'd1);
                            end
                            sejs_pkg::PH_RD_DATA: begin
                                em.cnt       = 2'd2;
                                n_bytes_left = bl_dec;
                                n_ram_cur    = ram_nx;
                                n_ee_cur     = ee_nx;
                                em.r0 = sejs_pkg::res_mem(sejs_pkg::KIND_STORE, r_ram_cur,
                                                          i_item.rx_byte, 1'b0);
                                if (r_bytes_left == 16'd1) begin
                                    n_active = 1'b0;
                                    n_phase  = sejs_pkg::PH_IDLE;
                                    em.r1    = sejs_pkg::res_done(sejs_pkg::JC_OK);
                                end else begin
                                    em.r1 = sejs_pkg::res_frame(8'h00, r_bytes_left != 16'd2);
                                end
                            end
                            sejs_pkg::PH_WR_WREN: begin
                                em.cnt  = 2'd1;
                                n_phase = sejs_pkg::PH_WR_RDSR;
                                em.r0   = sejs_pkg::res_frame(sejs_pkg::CMD_RDSR, 1'b1);
                            end
                            sejs_pkg::PH_WR_RDSR: begin
                                em.cnt  = 2'd1;
                                n_phase = sejs_pkg::PH_WR_STAT;
                                em.r0   = sejs_pkg::res_frame(8'h00, 1'b0);
                            end
                            sejs_pkg::PH_WR_STAT: begin
                                em.cnt = 2'd1;
                                if (!i_item.rx_byte[sejs_pkg::WEL_BIT]) begin
                                    n_active = 1'b0;
                                    n_phase  = sejs_pkg::PH_IDLE;
                                    em.r0    = sejs_pkg::res_done(sejs_pkg::JC_FAIL);
                                end else begin
                                    n_phase      = sejs_pkg::PH_WR_CMD;
                                    n_chunk_left = chunk_first;
                                    em.r0 = sejs_pkg::res_frame(sejs_pkg::CMD_WRITE, 1'b1);
                                end
                            end
                            sejs_pkg::PH_WR_AL: begin
                                em.cnt  = 2'd1;
                                n_phase = sejs_pkg::PH_WR_FETCH;
                                em.r0   = sejs_pkg::res_mem(sejs_pkg::KIND_FETCH, r_ram_cur,
                                                            8'h00, 1'b1);
                            end
                            sejs_pkg::PH_WR_DATA: begin
                                em.cnt       = 2'd1;
                                n_bytes_left = bl_dec;
                                n_chunk_left = ck_dec;
                                n_ram_cur    = ram_nx;
                                n_ee_cur     = ee_nx;
                                priority if (r_bytes_left == 16'd1) begin
                                    n_active = 1'b0;
                                    n_phase  = sejs_pkg::PH_IDLE;
                                    em.r0    = sejs_pkg::res_done(sejs_pkg::JC_OK);
                                end else if (r_chunk_left == CHUNK_ONE) begin
                                    div_load = 1'b1;
                                    div_x    = ee_nx;
                                    n_phase  = sejs_pkg::PH_WR_WREN;
                                    em.r0    = sejs_pkg::res_frame(sejs_pkg::CMD_WREN, 1'b0);
                                end else begin
                                    n_phase = sejs_pkg::PH_WR_FETCH;
                                    em.r0   = sejs_pkg::res_mem(sejs_pkg::KIND_FETCH, ram_nx,
                                                                8'h00, 1'b1);
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end

        em.r0.busy_res = n_active;
        em.r1.busy_res = n_active;
    end

    assign o_emit = em;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_phase  <= sejs_pkg::PH_IDLE;
        end else begin
            r_active <= n_active;
            r_phase  <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ee_start   <= n_ee_start;
        r_ram_start  <= n_ram_start;
        r_len        <= n_len;
        r_bytes_left <= n_bytes_left;
        r_chunk_left <= n_chunk_left;
        r_ee_cur     <= n_ee_cur;
        r_ram_cur    <= n_ram_cur;
    end

`ifndef SYNTH
    a_active_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == (r_phase != sejs_pkg::PH_IDLE))
        else $error("job active flag and phase disagree");

    a_bytes_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_bytes_left != 16'd0))
        else $error("active job with no bytes left");

    a_chunk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sejs_pkg::PH_WR_FETCH || r_phase == sejs_pkg::PH_WR_DATA)
        |-> (r_chunk_left != '0))
        else $error("page transfer with empty chunk");

    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && o_emit.cnt == 2'd2)
        |-> (i_item.req_type == sejs_pkg::REQ_FRAME && r_phase == sejs_pkg::PH_RD_DATA))
        else $error("two results outside read data phase");
`endif

endmodule

@@ design/sejs_outq.sv @@
module sejs_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sejs_pkg::t_emit   i_emit,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output sejs_pkg::t_res    o_data
);

    localparam int DEPTH = sejs_pkg::Q_DEPTH;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    sejs_pkg::t_res r_mem [DEPTH];
    logic [AW-1:0]  r_head;
    logic [AW-1:0]  r_tail;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  tail1;
    logic           pop;

    assign tail1   = r_tail + AW'(1);
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_head];
    assign o_room  = (r_count <= CW'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_emit.cnt != 2'd0) begin
            r_mem[r_tail] <= i_emit.r0;
        end
        if (i_emit.cnt == 2'd2) begin
            r_mem[tail1] <= i_emit.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= r_head + AW'(pop);
            r_tail  <= r_tail + AW'(i_emit.cnt);
            r_count <= r_count + CW'(i_emit.cnt) - CW'(pop);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(i_emit.cnt) + r_count) <= CW'(DEPTH))
        else $error("result queue overflow");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_emit.cnt != 2'd0) |=> o_valid)
        else $error("pushed result not visible");
`endif

endmodule
